/* sv/gpr_pkg.sv */
`default_nettype none
package gpr_pkg;

  localparam int MAX_JOYSTICKS = 8;
  localparam int MAX_BUTTONS   = 64;
  localparam int HEADER_LEN    = 4;
  localparam int AXES          = 2 * MAX_JOYSTICKS;
  localparam int BROWS         = (MAX_BUTTONS + 7) / 8;
  localparam int AX_W          = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int BROW_W        = (BROWS > 1) ? $clog2(BROWS) : 1;

  // fixed field widths
  localparam int JCNT_W = 4;
  localparam int BCNT_W = 7;

  localparam logic [2:0] KIND_CONNECT     = 3'd0;
  localparam logic [2:0] KIND_DISCONNECT  = 3'd1;
  localparam logic [2:0] KIND_BYTE        = 3'd2;
  localparam logic [2:0] KIND_READ_AXIS   = 3'd3;
  localparam logic [2:0] KIND_READ_BUTTON = 3'd4;

  localparam logic [1:0] RK_AXIS    = 2'd0;
  localparam logic [1:0] RK_BUTTON  = 2'd1;
  localparam logic [1:0] RK_VERDICT = 2'd2;

  typedef struct packed {
    logic              ax_we;
    logic [AX_W:0]     ax_waddr;
    logic [7:0]        ax_wdata;
    logic              bt_we;
    logic [BROW_W:0]   bt_waddr;
    logic [7:0]        bt_wdata;
    logic              rd_en;
    logic [AX_W:0]     ax_raddr;
    logic [BROW_W:0]   bt_raddr;
  } store_cmd_t;

endpackage
`default_nettype wire

/* sv/gpr_in_if.sv */
`default_nettype none
interface gpr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] item_index;

  modport source (output valid, kind, data_byte, last_byte, item_index, input ready);
  modport sink (input valid, kind, data_byte, last_byte, item_index, output ready);
endinterface
`default_nettype wire

/* sv/gpr_out_if.sv */
`default_nettype none
interface gpr_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic signed [7:0] axis_value;
  logic              button_pressed;
  logic [3:0]        joystick_count;
  logic [6:0]        button_count;
  logic              link_up;
  logic              data_valid;
  logic              report_accepted;

  modport source (output valid, result_kind, axis_value, button_pressed, joystick_count,
                  button_count, link_up, data_valid, report_accepted, input ready);
  modport sink (input valid, result_kind, axis_value, button_pressed, joystick_count,
                button_count, link_up, data_valid, report_accepted, output ready);
endinterface
`default_nettype wire

/* sv/gamepad_report_parser.sv */
// link events and report bytes are handled when accepted; a read does the synchronous store
// read first and then forms the answer word in S_READ
// a verdict word is registered in the cycle after its last byte, a read answer in S_READ from the store data
// a word is accepted whenever no read is in flight and the output register is free or being taken
// synchronous reset clears link, data and bank state; the axis and button stores are not cleared
`default_nettype none
module gamepad_report_parser (
  input wire logic  clk,
  input wire logic  rst,
  gpr_in_if.sink    req,
  gpr_out_if.source rsp
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t state;

  logic       connected_flag;
  logic       has_data_flag;
  logic       active_bank;
  logic [7:0] byte_counter;
  logic [7:0] shadow_joysticks;
  logic [7:0] shadow_buttons;
  logic [gpr_pkg::JCNT_W-1:0] active_joysticks;
  logic [gpr_pkg::BCNT_W-1:0] active_buttons;

  logic       rd_ok;
  logic       rd_is_axis;
  logic [2:0] rd_bit;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic signed [7:0] out_axis;
  logic              out_button;
  logic [3:0]        out_jcount;
  logic [6:0]        out_bcount;
  logic              out_link;
  logic              out_data;
  logic              out_acc;

  gpr_pkg::store_cmd_t cmd;
  logic [7:0] ax_rdata;
  logic [7:0] bt_rdata;

  logic       accept;
  logic       verdict_now;
  logic       store_en;
  logic [7:0] a_ofs;
  logic [8:0] nax;
  logic [8:0] row;
  logic       is_axis;
  logic       past_header;
  logic [7:0] jn_next;
  logic [7:0] bn_next;
  logic [7:0] cnt_inc;
  logic [9:0] need;
  logic       ok;
  logic       ax_ok;
  logic       bt_ok;

  assign req.ready   = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept      = req.valid && req.ready;
  assign verdict_now = accept && req.kind == gpr_pkg::KIND_BYTE && req.last_byte;

  // byte placement in the shadow bank
  assign store_en    = (byte_counter != 8'hFF);
  assign past_header = (byte_counter >= 8'(gpr_pkg::HEADER_LEN));
  assign a_ofs       = byte_counter - 8'(gpr_pkg::HEADER_LEN);
  assign nax         = {shadow_joysticks, 1'b0};
  assign is_axis     = ({1'b0, a_ofs} < nax);
  assign row         = {1'b0, a_ofs} - nax;

  assign jn_next = (store_en && byte_counter == 8'd2) ? req.data_byte : shadow_joysticks;
  assign bn_next = (store_en && byte_counter == 8'd3) ? req.data_byte : shadow_buttons;
  assign cnt_inc = store_en ? byte_counter + 8'd1 : byte_counter;

  assign need = 10'(gpr_pkg::HEADER_LEN) + {1'b0, jn_next, 1'b0}
              + 10'(({1'b0, bn_next} + 9'd7) >> 3);
  assign ok = (cnt_inc >= 8'(gpr_pkg::HEADER_LEN))
           && (9'(jn_next) <= 9'(gpr_pkg::MAX_JOYSTICKS))
           && (9'(bn_next) <= 9'(gpr_pkg::MAX_BUTTONS))
           && ({2'b0, cnt_inc} >= need);

  assign ax_ok = has_data_flag && (9'(req.item_index) < 9'({active_joysticks, 1'b0}))
              && (9'(req.item_index) < 9'(gpr_pkg::AXES));
  assign bt_ok = has_data_flag && (9'(req.item_index) < 9'(active_buttons))
              && (9'(req.item_index) < 9'(gpr_pkg::MAX_BUTTONS));

  always_comb begin
    cmd          = '0;
    cmd.ax_waddr = {~active_bank, a_ofs[gpr_pkg::AX_W-1:0]};
    cmd.ax_wdata = req.data_byte;
    cmd.bt_waddr = {~active_bank, row[gpr_pkg::BROW_W-1:0]};
    cmd.bt_wdata = req.data_byte;
    cmd.ax_raddr = {active_bank, req.item_index[gpr_pkg::AX_W-1:0]};
    cmd.bt_raddr = {active_bank, req.item_index[gpr_pkg::BROW_W+2:3]};
    if (accept && req.kind == gpr_pkg::KIND_BYTE && store_en && past_header) begin
      cmd.ax_we = is_axis && (9'(a_ofs) < 9'(gpr_pkg::AXES));
      cmd.bt_we = !is_axis && (row < 9'(gpr_pkg::BROWS));
    end
    cmd.rd_en = accept && (req.kind == gpr_pkg::KIND_READ_AXIS
                        || req.kind == gpr_pkg::KIND_READ_BUTTON);
  end

  gpr_store u_store (
    .clk      (clk),
    .cmd      (cmd),
    .ax_rdata (ax_rdata),
    .bt_rdata (bt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      connected_flag   <= 1'b0;
      has_data_flag    <= 1'b0;
      active_bank      <= 1'b0;
      byte_counter     <= 8'd0;
      shadow_joysticks <= 8'd0;
      shadow_buttons   <= 8'd0;
      active_joysticks <= '0;
      active_buttons   <= '0;
    end else begin
      if (rsp.valid && rsp.ready && !verdict_now) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.kind)
              gpr_pkg::KIND_CONNECT: begin
                connected_flag <= 1'b1;
                byte_counter   <= 8'd0;
              end
              gpr_pkg::KIND_DISCONNECT: begin
                connected_flag <= 1'b0;
                has_data_flag  <= 1'b0;
                byte_counter   <= 8'd0;
              end
              gpr_pkg::KIND_BYTE: begin
                shadow_joysticks <= jn_next;
                shadow_buttons   <= bn_next;
                if (!req.last_byte) begin
                  byte_counter <= cnt_inc;
                end else begin
                  byte_counter <= 8'd0;
                  if (ok) begin
                    active_bank      <= ~active_bank;
                    active_joysticks <= jn_next[gpr_pkg::JCNT_W-1:0];
                    active_buttons   <= bn_next[gpr_pkg::BCNT_W-1:0];
                    has_data_flag    <= 1'b1;
                  end
                  out_valid  <= 1'b1;
                  out_kind   <= gpr_pkg::RK_VERDICT;
                  out_axis   <= 8'sd0;
                  out_button <= 1'b0;
                  out_jcount <= ok ? jn_next[gpr_pkg::JCNT_W-1:0]
                                   : (has_data_flag ? active_joysticks : '0);
                  out_bcount <= ok ? bn_next[gpr_pkg::BCNT_W-1:0] : active_buttons;
                  out_link   <= connected_flag;
                  out_data   <= ok || has_data_flag;
                  out_acc    <= ok;
                end
              end
              gpr_pkg::KIND_READ_AXIS: begin
                rd_ok      <= ax_ok;
                rd_is_axis <= 1'b1;
                rd_bit     <= req.item_index[2:0];
                state      <= S_READ;
              end
              gpr_pkg::KIND_READ_BUTTON: begin
                rd_ok      <= bt_ok;
                rd_is_axis <= 1'b0;
                rd_bit     <= req.item_index[2:0];
                state      <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          out_kind   <= rd_is_axis ? gpr_pkg::RK_AXIS : gpr_pkg::RK_BUTTON;
          out_axis   <= (rd_is_axis && rd_ok) ? $signed(ax_rdata) : 8'sd0;
          out_button <= !rd_is_axis && rd_ok && bt_rdata[3'd7 - rd_bit];
          out_jcount <= has_data_flag ? active_joysticks : '0;
          out_bcount <= active_buttons;
          out_link   <= connected_flag;
          out_data   <= has_data_flag;
          out_acc    <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_kind     = out_kind;
  assign rsp.axis_value      = out_axis;
  assign rsp.button_pressed  = out_button;
  assign rsp.joystick_count  = out_jcount;
  assign rsp.button_count    = out_bcount;
  assign rsp.link_up         = out_link;
  assign rsp.data_valid      = out_data;
  assign rsp.report_accepted = out_acc;

  // the output register is always free while a store read is in flight
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid)
    else $error("output register busy during store read");

  // a bank swap always comes with committed data
  a_swap_has_data: assert property (@(posedge clk) disable iff (rst)
    !$stable(active_bank) |-> has_data_flag)
    else $error("bank swapped without data");

  // the committed joystick count never exceeds the limit
  a_jcount_range: assert property (@(posedge clk) disable iff (rst)
    5'(active_joysticks) <= 5'(gpr_pkg::MAX_JOYSTICKS))
    else $error("committed joystick count out of range");

  // a report byte ending a report always leaves the counter cleared
  a_counter_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && req.kind == gpr_pkg::KIND_BYTE && req.last_byte |=> byte_counter == 8'd0)
    else $error("byte counter not cleared after last byte");

endmodule
`default_nettype wire

/* sv/gpr_store.sv */
`default_nettype none
module gpr_store (
  input  wire logic               clk,
  input  wire gpr_pkg::store_cmd_t cmd,
  output logic [7:0]              ax_rdata,
  output logic [7:0]              bt_rdata
);

  // two banks each; the top address bit picks the bank
  logic [7:0] axis_mem   [2 ** (gpr_pkg::AX_W + 1)];
  // one row holds eight buttons, MSB is the lowest button number
  logic [7:0] button_mem [2 ** (gpr_pkg::BROW_W + 1)];

  always_ff @(posedge clk) begin
    if (cmd.ax_we) begin
      axis_mem[cmd.ax_waddr] <= cmd.ax_wdata;
    end
    if (cmd.rd_en) begin
      ax_rdata <= axis_mem[cmd.ax_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bt_we) begin
      button_mem[cmd.bt_waddr] <= cmd.bt_wdata;
    end
    if (cmd.rd_en) begin
      bt_rdata <= button_mem[cmd.bt_raddr];
    end
  end

endmodule
`default_nettype wire
